>>> src/rrss_pkg.sv
// shared types and constants for the round-robin slot scheduler
// command codes, controller states and the control/status structs
// no dependencies
package rrss_pkg;

    localparam int CMD_W   = 3;
    localparam int PID_W   = 16;   // task id port width
    localparam int PSLOT_W = 6;    // running slot port width
    localparam int POCC_W  = 7;    // occupied port width
    localparam int CNT_W   = 64;   // tick and dispatch totals
    localparam int QUANT_W = 10;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 10'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_SCHEDULE = 3'd2,
        CMD_TICK     = 3'd3,
        CMD_YIELD    = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_SCAN,
        S_ADD_WRITE,
        S_REM_SCAN,
        S_REM_SHIFT,
        S_REM_FIX,
        S_PICK,
        S_DISPATCH,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic scan_start;
        logic scan_run;
        logic add_write;
        logic shift_start;
        logic shift_run;
        logic rem_fix;
        logic pick_sched;
        logic pick_yield;
        logic pick_step;
        logic dispatch;
        logic clear_cur;
        logic tick_update;
        logic reload_slice;
        logic set_status;
        logic status_val;
        logic out_load;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic id_zero;
        logic full;
        logic count_zero;
        logic rcount_zero;
        logic rcount_le1;
        logic cur_id_zero;
        logic slice_expire;
        logic hit;
        logic scan_last_miss;
        logic shift_done;
        logic pick_hit;
        logic pick_oob;
    } sts_t;

endpackage

>>> src/rrss_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rrss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/rrss_datapath.sv
// slot table, runnable bits, counters and result registers of the scheduler
// depends on rrss_pkg and rrss_ram
module rrss_datapath #(
    parameter int MAX_SLOTS = 64,
    parameter int ID_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rrss_pkg::ctl_t                    ctl,
    output rrss_pkg::sts_t                    sts,
    input  logic                              cfg_we,
    input  logic [rrss_pkg::QUANT_W-1:0]      cfg_data,
    input  logic [rrss_pkg::CMD_W-1:0]        command,
    input  logic [rrss_pkg::PID_W-1:0]        task_id,
    output logic                              status,
    output logic [rrss_pkg::PID_W-1:0]        running_id,
    output logic [rrss_pkg::PSLOT_W-1:0]      running_slot,
    output logic [rrss_pkg::POCC_W-1:0]       occupied,
    output logic [rrss_pkg::CNT_W-1:0]        tick_total,
    output logic [rrss_pkg::CNT_W-1:0]        dispatch_total
);

    localparam int IdW   = (ID_BITS < rrss_pkg::PID_W) ? ID_BITS : rrss_pkg::PID_W;
    localparam int SlotW = $clog2(MAX_SLOTS);
    localparam int CntW  = SlotW + 1;
    localparam int QW    = rrss_pkg::QUANT_W;
    localparam int TW    = rrss_pkg::CNT_W;

    logic [rrss_pkg::CMD_W-1:0] cmd_reg;
    logic [IdW-1:0]             id_reg;
    logic [QW-1:0]              quantum_reg, quantum_next;
    logic [MAX_SLOTS-1:0]       rb_reg, rb_next;
    logic [CntW-1:0]            count_reg, count_next;
    logic [CntW-1:0]            rcount_reg, rcount_next;
    logic [SlotW-1:0]           cur_slot_reg, cur_slot_next;
    logic [IdW-1:0]             cur_id_reg, cur_id_next;
    logic [QW-1:0]              slice_reg, slice_next;
    logic [TW-1:0]              ticks_reg, ticks_next;
    logic [TW-1:0]              disp_reg, disp_next;
    logic [CntW-1:0]            idx_reg, idx_next;
    logic                       cmp_valid_reg, cmp_valid_next;
    logic [SlotW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic                       stat_reg, stat_next;

    logic                       out_status_reg;
    logic [IdW-1:0]             out_id_reg;
    logic [SlotW-1:0]           out_slot_reg;
    logic [CntW-1:0]            out_occ_reg;
    logic [TW-1:0]              out_ticks_reg;
    logic [TW-1:0]              out_disp_reg;

    logic                       ram_we;
    logic [SlotW-1:0]           ram_waddr;
    logic [IdW-1:0]             ram_wdata;
    logic [IdW-1:0]             ram_rdata;

    logic                       issue;
    logic [QW-1:0]              slice_dec;
    logic [CntW-1:0]            count_dec;
    logic [CntW-1:0]            yield_start;
    logic [MAX_SLOTS-1:0]       low_mask;

    rrss_ram #(
        .WIDTH (IdW),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[SlotW-1:0]),
        .rdata (ram_rdata)
    );

    // read issue during search and compaction sweeps
    assign issue     = (ctl.scan_run || ctl.shift_run) && (idx_reg < count_reg);
    assign slice_dec = (slice_reg != '0) ? slice_reg - QW'(1) : '0;
    assign count_dec = count_reg - CntW'(1);

    always_comb
    begin
        yield_start = CntW'(cur_slot_reg) + CntW'(1);
        if (yield_start == CntW'(MAX_SLOTS))
        begin
            yield_start = '0;
        end
    end

    // slots below the removed one keep their place
    always_comb
    begin
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            low_mask[k] = (CntW'(k) < CntW'(cmp_idx_reg));
        end
    end

    // table writes: append on add, move down by one on compaction
    always_comb
    begin
        ram_we    = ctl.add_write || (ctl.shift_run && cmp_valid_reg);
        ram_waddr = ctl.add_write ? count_reg[SlotW-1:0] : cmp_idx_reg - SlotW'(1);
        ram_wdata = ctl.add_write ? id_reg : ram_rdata;
    end

    always_comb
    begin
        quantum_next   = cfg_we ? cfg_data : quantum_reg;
        rb_next        = rb_reg;
        count_next     = count_reg;
        rcount_next    = rcount_reg;
        cur_slot_next  = cur_slot_reg;
        cur_id_next    = cur_id_reg;
        slice_next     = slice_reg;
        ticks_next     = ticks_reg;
        disp_next      = disp_reg;
        idx_next       = idx_reg;
        cmp_valid_next = issue;
        cmp_idx_next   = issue ? idx_reg[SlotW-1:0] : cmp_idx_reg;
        stat_next      = ctl.set_status ? ctl.status_val : stat_reg;

        if (issue)
        begin
            idx_next = idx_reg + CntW'(1);
        end
        if (ctl.scan_start)
        begin
            idx_next       = '0;
            cmp_valid_next = 1'b0;
        end
        if (ctl.add_write)
        begin
            rb_next[count_reg[SlotW-1:0]] = 1'b1;
            rcount_next = rcount_reg + CntW'(1);
            count_next  = count_reg + CntW'(1);
        end
        if (ctl.shift_start)
        begin
            rb_next        = (rb_reg & low_mask) | ((rb_reg >> 1) & ~low_mask);
            rcount_next    = rb_reg[cmp_idx_reg] ? rcount_reg - CntW'(1) : rcount_reg;
            idx_next       = CntW'(cmp_idx_reg) + CntW'(1);
            cmp_valid_next = 1'b0;
        end
        if (ctl.rem_fix)
        begin
            count_next = count_dec;
            if ((CntW'(cur_slot_reg) >= count_dec) && (count_dec != '0))
            begin
                cur_slot_next = '0;
            end
        end
        if (ctl.pick_sched)
        begin
            idx_next = CntW'(cur_slot_reg);
        end
        if (ctl.pick_yield)
        begin
            idx_next = yield_start;
        end
        if (ctl.pick_step && !rb_reg[idx_reg[SlotW-1:0]])
        begin
            if (idx_reg[SlotW-1:0] == SlotW'(MAX_SLOTS - 1))
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + CntW'(1);
            end
        end
        if (ctl.dispatch)
        begin
            cur_id_next   = ram_rdata;
            cur_slot_next = idx_reg[SlotW-1:0];
            disp_next     = disp_reg + TW'(1);
            slice_next    = quantum_reg;
        end
        if (ctl.clear_cur)
        begin
            cur_id_next = '0;
        end
        if (ctl.tick_update)
        begin
            ticks_next = ticks_reg + TW'(1);
            if (cur_id_reg != '0)
            begin
                slice_next = slice_dec;
            end
        end
        if (ctl.reload_slice)
        begin
            slice_next = quantum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg   <= rrss_pkg::QUANTUM_RESET;
            rb_reg        <= '0;
            count_reg     <= '0;
            rcount_reg    <= '0;
            cur_slot_reg  <= '0;
            cur_id_reg    <= '0;
            slice_reg     <= rrss_pkg::QUANTUM_RESET;
            ticks_reg     <= '0;
            disp_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            stat_reg      <= 1'b0;
        end
        else
        begin
            quantum_reg   <= quantum_next;
            rb_reg        <= rb_next;
            count_reg     <= count_next;
            rcount_reg    <= rcount_next;
            cur_slot_reg  <= cur_slot_next;
            cur_id_reg    <= cur_id_next;
            slice_reg     <= slice_next;
            ticks_reg     <= ticks_next;
            disp_reg      <= disp_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            stat_reg      <= stat_next;
        end
    end

    // command word and result word
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            cmd_reg <= command;
            id_reg  <= task_id[IdW-1:0];
        end
        if (ctl.out_load)
        begin
            out_status_reg <= stat_reg;
            out_id_reg     <= cur_id_reg;
            out_slot_reg   <= cur_slot_reg;
            out_occ_reg    <= count_reg;
            out_ticks_reg  <= ticks_reg;
            out_disp_reg   <= disp_reg;
        end
    end

    always_comb
    begin
        sts.cmd            = cmd_reg;
        sts.id_zero        = (id_reg == '0);
        sts.full           = (count_reg == CntW'(MAX_SLOTS));
        sts.count_zero     = (count_reg == '0);
        sts.rcount_zero    = (rcount_reg == '0);
        sts.rcount_le1     = (rcount_reg <= CntW'(1));
        sts.cur_id_zero    = (cur_id_reg == '0);
        sts.slice_expire   = (slice_dec == '0);
        sts.hit            = cmp_valid_reg && (ram_rdata == id_reg);
        sts.scan_last_miss = cmp_valid_reg && (ram_rdata != id_reg)
                             && (CntW'(cmp_idx_reg) == count_dec);
        sts.shift_done     = !cmp_valid_reg && (idx_reg >= count_reg);
        sts.pick_hit       = rb_reg[idx_reg[SlotW-1:0]];
        sts.pick_oob       = (idx_reg >= count_reg);
    end

    assign status         = out_status_reg;
    assign running_id     = rrss_pkg::PID_W'(out_id_reg);
    assign running_slot   = rrss_pkg::PSLOT_W'(out_slot_reg);
    assign occupied       = rrss_pkg::POCC_W'(out_occ_reg);
    assign tick_total     = out_ticks_reg;
    assign dispatch_total = out_disp_reg;

endmodule

>>> src/rrss_ctrl.sv
// command sequencer of the scheduler: decode, search, compaction, pick and result handoff
// depends on rrss_pkg
module rrss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  rrss_pkg::sts_t sts,
    output rrss_pkg::ctl_t ctl
);

    rrss_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             can_load;

    assign can_load = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrss_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rrss_pkg::S_DECODE;
                end
            end
            rrss_pkg::S_DECODE:
            begin
                case (sts.cmd)
                    rrss_pkg::CMD_ADD:
                    begin
                        if (sts.id_zero || sts.full)
                        begin
                            state_next = rrss_pkg::S_FINISH;
                        end
                        else if (sts.count_zero)
                        begin
                            state_next = rrss_pkg::S_ADD_WRITE;
                        end
                        else
                        begin
                            state_next = rrss_pkg::S_ADD_SCAN;
                        end
                    end
                    rrss_pkg::CMD_REMOVE:
                    begin
                        state_next = sts.count_zero ? rrss_pkg::S_FINISH
                                                    : rrss_pkg::S_REM_SCAN;
                    end
                    rrss_pkg::CMD_SCHEDULE:
                    begin
                        state_next = sts.rcount_zero ? rrss_pkg::S_FINISH
                                                     : rrss_pkg::S_PICK;
                    end
                    rrss_pkg::CMD_YIELD:
                    begin
                        state_next = (sts.cur_id_zero || sts.rcount_le1)
                                     ? rrss_pkg::S_FINISH : rrss_pkg::S_PICK;
                    end
                    rrss_pkg::CMD_TICK:
                    begin
                        if (sts.cur_id_zero || !sts.slice_expire || sts.rcount_le1)
                        begin
                            state_next = rrss_pkg::S_FINISH;
                        end
                        else
                        begin
                            state_next = rrss_pkg::S_PICK;
                        end
                    end
                    default:
                    begin
                        state_next = rrss_pkg::S_FINISH;
                    end
                endcase
            end
            rrss_pkg::S_ADD_SCAN:
            begin
                if (sts.hit)
                begin
                    state_next = rrss_pkg::S_FINISH;
                end
                else if (sts.scan_last_miss)
                begin
                    state_next = rrss_pkg::S_ADD_WRITE;
                end
            end
            rrss_pkg::S_ADD_WRITE:
            begin
                state_next = rrss_pkg::S_FINISH;
            end
            rrss_pkg::S_REM_SCAN:
            begin
                if (sts.hit)
                begin
                    state_next = rrss_pkg::S_REM_SHIFT;
                end
                else if (sts.scan_last_miss)
                begin
                    state_next = rrss_pkg::S_FINISH;
                end
            end
            rrss_pkg::S_REM_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = rrss_pkg::S_REM_FIX;
                end
            end
            rrss_pkg::S_REM_FIX:
            begin
                state_next = rrss_pkg::S_FINISH;
            end
            rrss_pkg::S_PICK:
            begin
                if (sts.pick_hit)
                begin
                    state_next = sts.pick_oob ? rrss_pkg::S_FINISH : rrss_pkg::S_DISPATCH;
                end
            end
            rrss_pkg::S_DISPATCH:
            begin
                state_next = rrss_pkg::S_FINISH;
            end
            rrss_pkg::S_FINISH:
            begin
                if (can_load)
                begin
                    state_next = rrss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rrss_pkg::S_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        ctl            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            rrss_pkg::S_IDLE:
            begin
                ctl.latch_in = in_valid;
            end
            rrss_pkg::S_DECODE:
            begin
                ctl.set_status = 1'b1;
                case (sts.cmd)
                    rrss_pkg::CMD_ADD:
                    begin
                        ctl.status_val = sts.id_zero || sts.full;
                        ctl.scan_start = 1'b1;
                    end
                    rrss_pkg::CMD_REMOVE:
                    begin
                        ctl.status_val = 1'b1;
                        ctl.scan_start = 1'b1;
                    end
                    rrss_pkg::CMD_SCHEDULE:
                    begin
                        ctl.status_val = sts.rcount_zero;
                        ctl.clear_cur  = sts.rcount_zero;
                        ctl.pick_sched = 1'b1;
                    end
                    rrss_pkg::CMD_YIELD:
                    begin
                        ctl.status_val = 1'b1;
                        ctl.pick_yield = 1'b1;
                    end
                    rrss_pkg::CMD_TICK:
                    begin
                        ctl.tick_update = 1'b1;
                        ctl.pick_yield  = 1'b1;
                        // expiry with no other runnable task: reload and report
                        if (!sts.cur_id_zero && sts.slice_expire && sts.rcount_le1)
                        begin
                            ctl.status_val   = 1'b1;
                            ctl.reload_slice = 1'b1;
                        end
                    end
                    default:
                    begin
                        ctl.status_val = 1'b1;
                    end
                endcase
            end
            rrss_pkg::S_ADD_SCAN:
            begin
                ctl.scan_run = 1'b1;
            end
            rrss_pkg::S_ADD_WRITE:
            begin
                ctl.add_write = 1'b1;
            end
            rrss_pkg::S_REM_SCAN:
            begin
                ctl.scan_run    = 1'b1;
                ctl.shift_start = sts.hit;
            end
            rrss_pkg::S_REM_SHIFT:
            begin
                ctl.shift_run = 1'b1;
            end
            rrss_pkg::S_REM_FIX:
            begin
                ctl.rem_fix    = 1'b1;
                ctl.set_status = 1'b1;
                ctl.status_val = 1'b0;
            end
            rrss_pkg::S_PICK:
            begin
                ctl.pick_step = 1'b1;
                if (sts.pick_hit && sts.pick_oob)
                begin
                    ctl.set_status   = 1'b1;
                    ctl.status_val   = 1'b1;
                    ctl.clear_cur    = (sts.cmd == rrss_pkg::CMD_SCHEDULE);
                    ctl.reload_slice = (sts.cmd == rrss_pkg::CMD_TICK);
                end
            end
            rrss_pkg::S_DISPATCH:
            begin
                ctl.dispatch   = 1'b1;
                ctl.set_status = 1'b1;
                ctl.status_val = 1'b0;
            end
            rrss_pkg::S_FINISH:
            begin
                ctl.out_load = can_load;
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrss_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != rrss_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> src/round_robin_slot_scheduler.sv
// add searches the table for the id, one table read per cycle; remove searches and
// compacts (search and compaction together sweep the table once); schedule, yield and
// an expiring tick scan the runnable bits, one runnable bit per cycle
// one word at a time; the next word is taken once the result sits in the output register
// reset: async active low clears control, counters, runnable bits; quantum and slice load 10
// the slot table itself is not cleared: only entries below the slot count are ever read
module round_robin_slot_scheduler #(
    parameter int MAX_SLOTS = 64,
    parameter int ID_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command word
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rrss_pkg::CMD_W-1:0]        command,
    input  logic [rrss_pkg::PID_W-1:0]        task_id,
    // result word
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              status,
    output logic [rrss_pkg::PID_W-1:0]        running_id,
    output logic [rrss_pkg::PSLOT_W-1:0]      running_slot,
    output logic [rrss_pkg::POCC_W-1:0]       occupied,
    output logic [rrss_pkg::CNT_W-1:0]        tick_total,
    output logic [rrss_pkg::CNT_W-1:0]        dispatch_total,
    // quantum register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rrss_pkg::QUANT_W-1:0]      cfg_data
);

    rrss_pkg::ctl_t ctl_s;
    rrss_pkg::sts_t sts_s;

    // user changes quantum only while idle (not enforced); a write is always taken
    assign cfg_ready = 1'b1;

    // sequencer: one state per phase of a command
    rrss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts_s),
        .ctl       (ctl_s)
    );

    // slot table ram, runnable bits, quantum slice and totals
    rrss_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .ID_BITS   (ID_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl_s),
        .sts            (sts_s),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .command        (command),
        .task_id        (task_id),
        .status         (status),
        .running_id     (running_id),
        .running_slot   (running_slot),
        .occupied       (occupied),
        .tick_total     (tick_total),
        .dispatch_total (dispatch_total)
    );

    // a taken word keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a word");

    // append only happens with room in the table
    a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_s.add_write |-> !sts_s.full)
        else $error("append into a full slot table");

    // compaction starts only from a matching entry
    a_shift_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_s.shift_start |-> sts_s.hit)
        else $error("compaction started without a match");

    // reported occupancy and slot stay inside the table
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupied <= rrss_pkg::POCC_W'(MAX_SLOTS))
                      && (running_slot <= rrss_pkg::PSLOT_W'(MAX_SLOTS - 1)))
        else $error("result occupancy or slot out of range");

endmodule
